// File: sv/ehp_pkg.sv
// ----------------------------------------------------------------------------
// ehp_pkg - shared types, constants and helpers for the header parser
// Frame state layout, result codes and the ones' complement adder.
// ----------------------------------------------------------------------------
package ehp_pkg;

  localparam logic [15:0] EthHdrLen  = 16'd14;
  localparam logic [16:0] ArpHdrLen  = 17'd28;
  localparam logic [16:0] IpMinLen   = 17'd20;
  localparam logic [16:0] TcpMinLen  = 17'd20;
  localparam logic [16:0] UdpMinLen  = 17'd8;
  localparam logic [15:0] TypeArp    = 16'h0806;
  localparam logic [15:0] TypeIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoIcmp  = 8'd1;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam logic [15:0] ArpOpReq   = 16'd1;
  localparam logic [15:0] ArpOpReply = 16'd2;

  // frame_class codes
  localparam logic [2:0] FcRunt  = 3'd0;
  localparam logic [2:0] FcArp   = 3'd1;
  localparam logic [2:0] FcIpv4  = 3'd2;
  localparam logic [2:0] FcOther = 3'd3;
  localparam logic [2:0] FcTrunc = 3'd4;

  // arp_kind codes
  localparam logic [1:0] ArpNone  = 2'd0;
  localparam logic [1:0] ArpReq   = 2'd1;
  localparam logic [1:0] ArpReply = 2'd2;
  localparam logic [1:0] ArpUnk   = 2'd3;

  // transport_class codes
  localparam logic [2:0] TcNone  = 3'd0;
  localparam logic [2:0] TcIcmp  = 3'd1;
  localparam logic [2:0] TcTcp   = 3'd2;
  localparam logic [2:0] TcUdp   = 3'd3;
  localparam logic [2:0] TcOther = 3'd4;

  // tcp_check_status codes
  localparam logic [1:0] TcpNotChecked = 2'd0;
  localparam logic [1:0] TcpGood       = 2'd1;
  localparam logic [1:0] TcpBad        = 2'd2;
  localparam logic [1:0] TcpBeyond     = 2'd3;

  localparam int unsigned OutWidth = 88;

  typedef struct packed {
    logic [15:0] type_word;
    logic [15:0] arp_opcode;
    logic [7:0]  version_ihl;
    logic [15:0] ip_length_total;
    logic [7:0]  protocol_number;
    logic [15:0] ip_got_checksum;
    logic [15:0] ip_running_sum;
    logic [15:0] tcp_running_sum;
    logic [15:0] tcp_got_checksum;
    logic [15:0] port_source;
    logic [15:0] port_dest;
    logic [7:0]  flags_byte;
    logic [7:0]  pending_high_byte;
  } state_t;

  // frame as seen at its last byte
  typedef struct packed {
    logic [16:0] frame_len;
    state_t      st;
  } snap_t;

  // 16-bit ones' complement sum of three words, end-around carry
  function automatic logic [15:0] ones_add3(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c);
    logic [17:0] t;
    logic [16:0] f;
    t = {2'b00, a} + {2'b00, b} + {2'b00, c};
    f = {1'b0, t[15:0]} + {15'd0, t[17:16]};
    return f[15:0] + {15'd0, f[16]};
  endfunction

endpackage

// File: sv/ehp_frame_track.sv
// ----------------------------------------------------------------------------
// ehp_frame_track - per-byte header capture and running checksums
// Updates the frame state on each accepted byte and snapshots it on the last.
// ----------------------------------------------------------------------------
module ehp_frame_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_last_i,
  input  logic                load_ok_i,
  output logic                snap_vld_o,
  output ehp_pkg::snap_t      snap_o
);

  logic [15:0]     pos_q, pos_d;
  logic            past_end_q, past_end_d;
  ehp_pkg::state_t st_q, st_d, nxt;
  logic            snap_vld_q, snap_vld_d;
  ehp_pkg::snap_t  snap_q, snap_d;

  logic [7:0]  vi_n;
  logic [15:0] len_n;
  logic [5:0]  hl;
  logic [6:0]  ts;
  logic [15:0] part, rel, seg, opx, opy;
  logic        ge_eth, ge_ts;

  always_comb begin
    nxt    = st_q;
    vi_n   = (pos_q == 16'd14) ? data_byte_i : st_q.version_ihl;
    len_n  = (pos_q == 16'd16 || pos_q == 16'd17) ?
             {st_q.ip_length_total[7:0], data_byte_i} : st_q.ip_length_total;
    hl     = {vi_n[3:0], 2'b00};
    ts     = 7'(ehp_pkg::EthHdrLen) + {1'b0, hl};
    part   = pos_q[0] ? {8'd0, data_byte_i} : {data_byte_i, 8'd0};
    ge_eth = pos_q >= ehp_pkg::EthHdrLen;
    ge_ts  = pos_q >= {9'd0, ts};
    rel    = pos_q - {9'd0, ts};
    seg    = (len_n >= {10'd0, hl}) ? len_n - {10'd0, hl} : 16'd0;

    nxt.version_ihl     = vi_n;
    nxt.ip_length_total = len_n;
    if (pos_q == 16'd12 || pos_q == 16'd13)
      nxt.type_word = {st_q.type_word[7:0], data_byte_i};
    if (pos_q == 16'd20 || pos_q == 16'd21)
      nxt.arp_opcode = {st_q.arp_opcode[7:0], data_byte_i};
    if (pos_q == 16'd15) nxt.pending_high_byte = data_byte_i;
    if (pos_q == 16'd23) nxt.protocol_number = data_byte_i;
    if (pos_q == 16'd24 || pos_q == 16'd25)
      nxt.ip_got_checksum = {st_q.ip_got_checksum[7:0], data_byte_i};

    if (ge_eth && pos_q < {9'd0, ts} && pos_q != 16'd24 && pos_q != 16'd25)
      nxt.ip_running_sum = ehp_pkg::ones_add3(st_q.ip_running_sum, part, 16'd0);

    // zero IHL: the overlapping segment words are folded in once length is known
    if (pos_q == 16'd17 && hl == 6'd0) begin
      opx = (len_n >= 16'd2) ? {st_q.version_ihl, st_q.pending_high_byte} :
            (len_n >= 16'd1) ? {st_q.version_ihl, 8'd0} : 16'd0;
      opy = (len_n >= 16'd4) ? len_n :
            (len_n >= 16'd3) ? {len_n[15:8], 8'd0} : 16'd0;
    end else begin
      opx = (pos_q >= 16'd26 && pos_q <= 16'd33) ? part : 16'd0;
      opy = (ge_ts && pos_q >= 16'd18 && rel < seg && rel != 16'd16 && rel != 16'd17) ?
            part : 16'd0;
    end
    nxt.tcp_running_sum = ehp_pkg::ones_add3(st_q.tcp_running_sum, opx, opy);

    if (ge_ts) begin
      if (rel <= 16'd1)
        nxt.port_source = {st_q.port_source[7:0], data_byte_i};
      else if (rel <= 16'd3)
        nxt.port_dest = {st_q.port_dest[7:0], data_byte_i};
      else if (rel == 16'd13)
        nxt.flags_byte = data_byte_i;
      else if (rel == 16'd16 || rel == 16'd17)
        nxt.tcp_got_checksum = {st_q.tcp_got_checksum[7:0], data_byte_i};
    end

    if (past_end_q) nxt = st_q;
  end

  always_comb begin
    st_d       = st_q;
    pos_d      = pos_q;
    past_end_d = past_end_q;
    snap_vld_d = snap_vld_q && !load_ok_i;
    snap_d     = snap_q;
    if (acc_i) begin
      if (frame_last_i) begin
        st_d              = '0;
        pos_d             = '0;
        past_end_d        = 1'b0;
        snap_vld_d        = 1'b1;
        snap_d.st         = nxt;
        snap_d.frame_len  = past_end_q ? 17'h10000 : {1'b0, pos_q} + 17'd1;
      end else if (!past_end_q) begin
        st_d = nxt;
        if (pos_q != 16'hFFFF) pos_d = pos_q + 16'd1;
        else past_end_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      pos_q      <= '0;
      past_end_q <= 1'b0;
      snap_vld_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      pos_q      <= pos_d;
      past_end_q <= past_end_d;
      snap_vld_q <= snap_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_vld_o = snap_vld_q;
  assign snap_o     = snap_q;

endmodule

// File: sv/ehp_summary.sv
// ----------------------------------------------------------------------------
// ehp_summary - frame classification and final checksum verdicts
// Turns a frame snapshot into the packed summary held in the output register.
// ----------------------------------------------------------------------------
module ehp_summary (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              snap_vld_i,
  input  ehp_pkg::snap_t                    snap_i,
  input  logic                              m_axis_tready,
  output logic                              m_axis_tvalid,
  output logic [ehp_pkg::OutWidth-1:0]      m_axis_tdata,
  output logic                              load_ok_o
);

  logic                         out_vld_q, out_vld_d;
  logic [ehp_pkg::OutWidth-1:0] out_q, out_d;

  logic [2:0]  fc, tc;
  logic [15:0] et, sport, dport, s, seg;
  logic [1:0]  ak, tstat;
  logic [3:0]  ver;
  logic [5:0]  hl, hb;
  logic [7:0]  proto, flags;
  logic        ipok;
  logic [16:0] len, rem, pay;

  always_comb begin
    fc = ehp_pkg::FcRunt; et = '0; ak = ehp_pkg::ArpNone; ver = '0; hb = '0;
    proto = '0; ipok = 1'b0; tc = ehp_pkg::TcNone; sport = '0; dport = '0;
    flags = '0; tstat = ehp_pkg::TcpNotChecked;
    len = snap_i.frame_len;
    rem = len - {1'b0, ehp_pkg::EthHdrLen};
    hl  = {snap_i.st.version_ihl[3:0], 2'b00};
    pay = rem - {11'd0, hl};
    seg = snap_i.st.ip_length_total - {10'd0, hl};
    s   = ehp_pkg::ones_add3(snap_i.st.tcp_running_sum, 16'(ehp_pkg::ProtoTcp), seg);
    if (len >= {1'b0, ehp_pkg::EthHdrLen}) begin
      et = snap_i.st.type_word;
      if (et == ehp_pkg::TypeArp) begin
        fc = ehp_pkg::FcArp;
        if (rem >= ehp_pkg::ArpHdrLen)
          ak = (snap_i.st.arp_opcode == ehp_pkg::ArpOpReq)   ? ehp_pkg::ArpReq :
               (snap_i.st.arp_opcode == ehp_pkg::ArpOpReply) ? ehp_pkg::ArpReply :
                                                               ehp_pkg::ArpUnk;
      end else if (et != ehp_pkg::TypeIpv4) begin
        fc = ehp_pkg::FcOther;
      end else if (rem < ehp_pkg::IpMinLen || rem < {11'd0, hl}) begin
        fc = ehp_pkg::FcTrunc;
      end else begin
        fc    = ehp_pkg::FcIpv4;
        ver   = snap_i.st.version_ihl[7:4];
        hb    = hl;
        proto = snap_i.st.protocol_number;
        ipok  = (~snap_i.st.ip_running_sum == snap_i.st.ip_got_checksum);
        unique case (proto)
          ehp_pkg::ProtoIcmp: tc = ehp_pkg::TcIcmp;
          ehp_pkg::ProtoTcp: begin
            tc = ehp_pkg::TcTcp;
            if (pay >= ehp_pkg::TcpMinLen &&
                snap_i.st.ip_length_total >= {10'd0, hl}) begin
              sport = snap_i.st.port_source;
              dport = snap_i.st.port_dest;
              flags = snap_i.st.flags_byte;
              if ({1'b0, seg} + {11'd0, hl} + {1'b0, ehp_pkg::EthHdrLen} > len)
                tstat = ehp_pkg::TcpBeyond;
              else
                tstat = (~s == snap_i.st.tcp_got_checksum) ? ehp_pkg::TcpGood :
                                                             ehp_pkg::TcpBad;
            end
          end
          ehp_pkg::ProtoUdp: begin
            tc = ehp_pkg::TcUdp;
            if (pay >= ehp_pkg::UdpMinLen) begin
              sport = snap_i.st.port_source;
              dport = snap_i.st.port_dest;
            end
          end
          default: tc = ehp_pkg::TcOther;
        endcase
      end
    end
  end

  assign load_ok_o = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (load_ok_o) begin
      out_vld_d = snap_vld_i;
      out_d     = {3'd0, tstat, flags, dport, sport, tc, ipok, proto, hb, ver, ak, et, fc};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// File: sv/ethernet_ipv4_header_parser.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser - streaming Ethernet/ARP/IPv4/TCP/UDP summary
// Byte-wise header parser with IP and TCP checksum verification.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one frame byte per request on s_axis_tdata, wire order,
//   with s_axis_tlast on the final byte. Master side gives one summary per
//   frame, passed on from the snapshot register to the output register.
//   Throughput is one byte per cycle while s_axis_tready is high: each byte
//   only passes a position compare and a 16-bit end-around add into the
//   frame state registers. On the last byte the state is copied to a
//   snapshot register and cleared, so the next frame may start without
//   waiting for its summary. The snapshot is classified into the output register once that register is free.
//   If the receiver stalls, bytes keep flowing until both the snapshot and
//   the output register hold a summary; s_axis_tready then drops until the
//   output is taken.
//   Reset clears the frame state and drops any pending summary.
// ----------------------------------------------------------------------------
module ethernet_ipv4_header_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tlast,  // frame_last
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] frame_class, [18:3] ether_type, [20:19] arp_kind, [24:21] ip_version,
  // [30:25] ip_header_bytes, [38:31] ip_protocol, [39] ip_checksum_ok,
  // [42:40] transport_class, [58:43] source_port, [74:59] dest_port,
  // [82:75] tcp_flag_bits, [84:83] tcp_check_status, [87:85] zero
  output logic [ehp_pkg::OutWidth-1:0] m_axis_tdata
);

  logic           snap_vld, load_ok, acc;
  ehp_pkg::snap_t snap;

  assign s_axis_tready = !snap_vld || load_ok;
  assign acc           = s_axis_tvalid && s_axis_tready;

  ehp_frame_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .data_byte_i  (s_axis_tdata),
    .frame_last_i (s_axis_tlast),
    .load_ok_i    (load_ok),
    .snap_vld_o   (snap_vld),
    .snap_o       (snap)
  );

  ehp_summary u_summary (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .snap_vld_i    (snap_vld),
    .snap_i        (snap),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .load_ok_o     (load_ok)
  );

  // both summary slots full and output stalled: no byte may be taken
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_vld && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("byte accepted with no room for a summary");

  a_last_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> snap_vld)
    else $error("last byte did not produce a snapshot");

  a_runt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == ehp_pkg::FcRunt |-> m_axis_tdata[87:3] == '0)
    else $error("runt summary carries field data");

  a_tc_ipv4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[42:40] != ehp_pkg::TcNone
      |-> m_axis_tdata[2:0] == ehp_pkg::FcIpv4)
    else $error("transport class outside an IPv4 frame");

endmodule
